[hw/rtl/vsl_pkg.sv]
package vsl_pkg;

    // Coordinate format
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;

    // Register and field widths
    localparam int SPEED_W = 24;
    localparam int SNAP_W  = 16;
    localparam int DT_W    = 16;
    localparam int REQ_W   = 2;

    // Datapath widths
    localparam int MAG_W   = COORD_W + 1;            // |goal - pos|
    localparam int LO_W    = MAG_W / 2;              // low half for squaring
    localparam int HI_W    = MAG_W - LO_W;
    localparam int STEP_SH = 32 - FRAC_BITS;         // Q.32 product down to coordinate LSBs
    localparam int STEP_W  = SPEED_W + DT_W - STEP_SH;
    localparam int PROD_W  = MAG_W + STEP_W;
    localparam int SUM_W   = 2 * MAG_W;              // sum of three squares fits
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int CS_W    = REM_W + 2;
    localparam int ITER_N  = ROOT_W;
    localparam int CNT_W   = $clog2(ITER_N + 1);
    localparam int SQ_LAST = 6;                      // six half products, then the step product

    localparam logic [SNAP_W-1:0] SNAP_RESET = SNAP_W'(66);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SNAP = 2'd2;

    // Register indexes
    localparam logic CFG_SPEED = 1'b0;
    localparam logic CFG_SNAP  = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic [DT_W-1:0]           delta_time;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      arrived;
    } t_out_item;

endpackage

[hw/rtl/vsl_mul.sv]
module vsl_mul (
    input  logic                       i_clk,
    input  logic [vsl_pkg::MAG_W-1:0]  i_a,
    input  logic [vsl_pkg::STEP_W-1:0] i_b,
    output logic [vsl_pkg::PROD_W-1:0] o_p
);

    // Registered product
    always_ff @(posedge i_clk) begin
        o_p <= vsl_pkg::PROD_W'(i_a) * vsl_pkg::PROD_W'(i_b);
    end

endmodule

[hw/rtl/vsl_cmpsub.sv]
module vsl_cmpsub (
    input  logic [vsl_pkg::CS_W-1:0] i_a,
    input  logic [vsl_pkg::CS_W-1:0] i_b,
    output logic                     o_ge,
    output logic [vsl_pkg::CS_W-1:0] o_diff
);

    logic [vsl_pkg::CS_W:0] w_sub;

    // One restoring step: borrow out of a - b decides the result bit
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[vsl_pkg::CS_W];
    assign o_diff = w_sub[vsl_pkg::CS_W-1:0];

endmodule

[hw/rtl/vector_slew_limiter_3d_unit.sv]
// Vector slew limiter, 3D: moves a stored position towards a stored target at
// a bounded speed, signed Q16.16 coordinates.
// Input channel (i_in_valid / o_in_stall, payload i_in_data): a transaction is
// taken when valid is high and stall is low. A tick computes the step
// (move_speed * delta_time) and the distance to the target, then snaps to the
// target or moves along the difference by step / distance. Set-target and snap
// transactions load the target, or target and position.
// Output channel (o_out_valid / i_out_stall, payload o_out_data): exactly one
// result per input transaction: the position after it and the arrived flag.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 move_speed, 1 snap_distance;
// write only while the block is idle.
// Sequence: set-target, snap and unknown requests go straight to the output
// register. A tick squares the magnitudes, forms the step on the multiplier
// and takes the root; one that snaps or holds stops there, one that moves then
// runs a product and a divide per axis, paced by the one shared compare-subtract
// unit (one root or quotient bit per cycle) and the one multiplier. One
// transaction is in work at a time; o_in_stall is high until its result is
// loaded. A stalled result waits in the output register; the next input may be
// taken meanwhile, and its result is held back until the register is free.
// Reset clears position and target to zero, move_speed to 0, snap_distance to 66.
module vector_slew_limiter_3d_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  vsl_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output vsl_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [vsl_pkg::SPEED_W-1:0] i_cfg_data
);

    // Sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQ     = 4'd1;
    localparam logic [3:0] S_STEP   = 4'd2;
    localparam logic [3:0] S_SQRT   = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_PROD   = 4'd5;
    localparam logic [3:0] S_DIVLD  = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_APPLY  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    localparam int CW = vsl_pkg::COORD_W;

    logic [3:0]                    r_state;
    logic [CW-1:0]                 r_cur [3];
    logic [CW-1:0]                 r_goal [3];
    logic [vsl_pkg::SPEED_W-1:0]   r_speed;
    logic [vsl_pkg::SNAP_W-1:0]    r_snap;
    logic [vsl_pkg::MAG_W-1:0]     r_mag [3];
    logic [2:0]                    r_neg;
    logic [vsl_pkg::DT_W-1:0]      r_dt;
    logic [vsl_pkg::STEP_W-1:0]    r_step;
    logic [vsl_pkg::SUM_W-1:0]     r_sum;
    logic [vsl_pkg::REM_W-1:0]     r_rem;
    logic [vsl_pkg::ROOT_W-1:0]    r_root;
    logic [vsl_pkg::ROOT_W-1:0]    r_dvd;
    logic [vsl_pkg::ROOT_W-1:0]    r_quot;
    logic [vsl_pkg::CNT_W-1:0]     r_cnt;
    logic [1:0]                    r_axis;
    logic                          r_out_valid;
    vsl_pkg::t_out_item            r_out;

    logic                          w_in_fire;
    logic                          w_out_free;
    logic [1:0]                    w_mag_idx;
    logic [vsl_pkg::MAG_W-1:0]     w_mag;
    logic [vsl_pkg::MAG_W-1:0]     w_mul_a;
    logic [vsl_pkg::STEP_W-1:0]    w_mul_b;
    logic [vsl_pkg::PROD_W-1:0]    w_prod;
    logic [vsl_pkg::SUM_W-1:0]     w_sq_term;
    logic [vsl_pkg::CS_W-1:0]      w_cs_a;
    logic [vsl_pkg::CS_W-1:0]      w_cs_b;
    logic                          w_cs_ge;
    logic [vsl_pkg::CS_W-1:0]      w_cs_diff;
    logic [vsl_pkg::CS_W-1:0]      w_sqrt_r;
    logic [vsl_pkg::CS_W-1:0]      w_div_r;
    logic [CW-1:0]                 w_tgt [3];
    logic [CW:0]                   w_diff [3];
    logic [CW+1:0]                 w_moved;
    logic                          w_snap_hit;
    logic [3:0]                    n_state;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_fire   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_tgt[0] = i_in_data.target_x;
    assign w_tgt[1] = i_in_data.target_y;
    assign w_tgt[2] = i_in_data.target_z;

    // Signed difference goal - position per axis, one bit wider
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = {r_goal[k][CW-1], r_goal[k]} - {r_cur[k][CW-1], r_cur[k]};
        end
    end

    // Axis pick for the multiplier: squaring walks axes by counter, product by r_axis
    assign w_mag_idx = (r_state == S_SQ) ? r_cnt[2:1] : r_axis;

    always_comb begin
        case (w_mag_idx)
            2'd0:    w_mag = r_mag[0];
            2'd1:    w_mag = r_mag[1];
            2'd2:    w_mag = r_mag[2];
            default: w_mag = '0;
        endcase
    end

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_SQ: begin
                if (r_cnt < vsl_pkg::CNT_W'(vsl_pkg::SQ_LAST)) begin
                    w_mul_a = w_mag;
                    if (r_cnt[0]) begin
                        w_mul_b = vsl_pkg::STEP_W'(w_mag[vsl_pkg::MAG_W-1:vsl_pkg::LO_W]);
                    end else begin
                        w_mul_b = vsl_pkg::STEP_W'(w_mag[vsl_pkg::LO_W-1:0]);
                    end
                end else begin
                    w_mul_a = vsl_pkg::MAG_W'(r_speed);
                    w_mul_b = vsl_pkg::STEP_W'(r_dt);
                end
            end
            S_PROD: begin
                w_mul_a = w_mag;
                w_mul_b = r_step;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    vsl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // Product issued last cycle: odd counts were high halves, weight 2^LO_W
    always_comb begin
        if (r_cnt[0]) begin
            w_sq_term = vsl_pkg::SUM_W'(w_prod);
        end else begin
            w_sq_term = vsl_pkg::SUM_W'(w_prod) << vsl_pkg::LO_W;
        end
    end

    // Shared compare-subtract: root digits and quotient bits
    assign w_sqrt_r = {r_rem, r_sum[vsl_pkg::SUM_W-1 -: 2]};
    assign w_div_r  = vsl_pkg::CS_W'({r_rem[vsl_pkg::ROOT_W-1:0], r_dvd[vsl_pkg::ROOT_W-1]});

    always_comb begin
        if (r_state == S_SQRT) begin
            w_cs_a = w_sqrt_r;
            w_cs_b = vsl_pkg::CS_W'({r_root, 2'b01});
        end else begin
            w_cs_a = w_div_r;
            w_cs_b = vsl_pkg::CS_W'(r_root);
        end
    end

    vsl_cmpsub u_cmpsub (
        .i_a    (w_cs_a),
        .i_b    (w_cs_b),
        .o_ge   (w_cs_ge),
        .o_diff (w_cs_diff)
    );

    assign w_snap_hit = (r_root <= vsl_pkg::ROOT_W'(r_snap)) ||
                        (r_root <= vsl_pkg::ROOT_W'(r_step));

    // Apply signed move on the current axis
    always_comb begin
        if (r_neg[r_axis]) begin
            w_moved = {{2{r_cur[r_axis][CW-1]}}, r_cur[r_axis]} - {1'b0, r_quot};
        end else begin
            w_moved = {{2{r_cur[r_axis][CW-1]}}, r_cur[r_axis]} + {1'b0, r_quot};
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = (i_in_data.req_type == vsl_pkg::REQ_TICK) ? S_SQ : S_OUT;
                end
            end
            S_SQ: begin
                if (r_cnt == vsl_pkg::CNT_W'(vsl_pkg::SQ_LAST)) begin
                    n_state = S_STEP;
                end
            end
            S_STEP:   n_state = S_SQRT;
            S_SQRT: begin
                if (r_cnt == vsl_pkg::CNT_W'(vsl_pkg::ITER_N - 1)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: n_state = (w_snap_hit || (r_step == '0)) ? S_OUT : S_PROD;
            S_PROD:   n_state = S_DIVLD;
            S_DIVLD:  n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == vsl_pkg::CNT_W'(vsl_pkg::ITER_N - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY:  n_state = (r_axis == 2'd2) ? S_OUT : S_PROD;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_speed     <= '0;
            r_snap      <= vsl_pkg::SNAP_RESET;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_cur[k]  <= '0;
                r_goal[k] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    vsl_pkg::CFG_SPEED: r_speed <= i_cfg_data;
                    vsl_pkg::CFG_SNAP:  r_snap  <= i_cfg_data[vsl_pkg::SNAP_W-1:0];
                    default:            r_speed <= r_speed;
                endcase
            end

            // Load targets on set and snap
            if (w_in_fire) begin
                if (i_in_data.req_type == vsl_pkg::REQ_SET ||
                    i_in_data.req_type == vsl_pkg::REQ_SNAP) begin
                    for (int k = 0; k < 3; k++) begin
                        r_goal[k] <= w_tgt[k];
                        if (i_in_data.req_type == vsl_pkg::REQ_SNAP) begin
                            r_cur[k] <= w_tgt[k];
                        end
                    end
                end
            end

            if (r_state == S_DECIDE && w_snap_hit) begin
                for (int k = 0; k < 3; k++) begin
                    r_cur[k] <= r_goal[k];
                end
            end

            if (r_state == S_APPLY) begin
                r_cur[r_axis] <= w_moved[CW-1:0];
            end

            // Output register: drop when taken, load the finished result
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Work registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cnt  <= '0;
                r_sum  <= '0;
                r_axis <= 2'd0;
                r_dt   <= i_in_data.delta_time;
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= w_diff[k][CW];
                    r_mag[k] <= w_diff[k][CW] ? (vsl_pkg::MAG_W'(0) - w_diff[k]) : w_diff[k];
                end
            end
            S_SQ: begin
                if (r_cnt != '0) begin
                    r_sum <= r_sum + w_sq_term;
                end
                r_cnt <= r_cnt + vsl_pkg::CNT_W'(1);
            end
            S_STEP: begin
                r_step <= w_prod[vsl_pkg::STEP_SH +: vsl_pkg::STEP_W];
                r_cnt  <= '0;
                r_rem  <= '0;
                r_root <= '0;
            end
            S_SQRT: begin
                r_rem  <= w_cs_ge ? w_cs_diff[vsl_pkg::REM_W-1:0]
                                  : w_sqrt_r[vsl_pkg::REM_W-1:0];
                r_root <= {r_root[vsl_pkg::ROOT_W-2:0], w_cs_ge};
                r_sum  <= r_sum << 2;
                r_cnt  <= r_cnt + vsl_pkg::CNT_W'(1);
            end
            S_DIVLD: begin
                r_rem  <= vsl_pkg::REM_W'(w_prod[vsl_pkg::PROD_W-1:vsl_pkg::ROOT_W]);
                r_dvd  <= w_prod[vsl_pkg::ROOT_W-1:0];
                r_quot <= '0;
                r_cnt  <= '0;
            end
            S_DIV: begin
                r_rem  <= w_cs_ge ? w_cs_diff[vsl_pkg::REM_W-1:0]
                                  : w_div_r[vsl_pkg::REM_W-1:0];
                r_quot <= {r_quot[vsl_pkg::ROOT_W-2:0], w_cs_ge};
                r_dvd  <= r_dvd << 1;
                r_cnt  <= r_cnt + vsl_pkg::CNT_W'(1);
            end
            S_APPLY: begin
                r_axis <= r_axis + 2'd1;
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out.pos_x   <= r_cur[0];
                    r_out.pos_y   <= r_cur[1];
                    r_out.pos_z   <= r_cur[2];
                    r_out.arrived <= (r_cur[0] == r_goal[0]) && (r_cur[1] == r_goal[1]) &&
                                     (r_cur[2] == r_goal[2]);
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // An accepted transaction blocks the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> o_in_stall)
        else $error("input not stalled after accepting a transaction");

    // Restoring root: partial remainder never exceeds twice the partial root
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_rem <= vsl_pkg::REM_W'({r_root, 1'b0})))
        else $error("root remainder out of range");

    // Restoring divide: remainder stays below the distance
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < vsl_pkg::REM_W'(r_root)))
        else $error("divide remainder not below divisor");

    // A move never exceeds the remaining difference on its axis
    a_no_overshoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> (r_quot <= w_mag))
        else $error("move larger than distance on axis");

endmodule
